// ----- design/weighted_set_similarity_unit_assert.svh -----
// Assertion macros shared by the weighted set similarity RTL.
`ifndef WEIGHTED_SET_SIMILARITY_UNIT_ASSERT_SVH
`define WEIGHTED_SET_SIMILARITY_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define WSSU_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define WSSU_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/wss_pkg.sv -----
// Types and constants for the weighted set similarity unit.
package wss_pkg;

    // Operation codes carried in s_axis_tuser
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPARE = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;

    localparam int unsigned TOTAL_W = 24;
    localparam int unsigned UNION_W = 25;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned FRAC_FB = 16;   // fraction bits of Q1.16
    localparam int unsigned DVD_W   = TOTAL_W + FRAC_FB;
    localparam int unsigned STEP_W  = $clog2(DVD_W);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [FRAC_W-1:0]  FRAC_ONE  = {1'b1, {FRAC_FB{1'b0}}};

    localparam int unsigned M_DATA_W = ((UNION_W + TOTAL_W + FRAC_W + 1 + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_FIX,
        ST_ACC_A,
        ST_ACC_B,
        ST_ACC_S,
        ST_UNI_ADD,
        ST_UNI_SUB,
        ST_DIV,
        ST_FINAL
    } state_t;

endpackage

// ----- design/weighted_set_similarity_unit.sv -----
// Weighted set similarity unit: top level, table scan, shared adder and divider.

// Weighted Jaccard similarity of two key-to-count multisets. Each transfer on the
// slave stream carries an operation in s_axis_tuser: load (0) stores a set A
// (key, count) pair in an internal table of TABLE_DEPTH entries, overwriting the
// count of a key already present; compare (1) adds a set B count to the B total and,
// on a key hit, adds the smaller count to the intersection; finish (2) sends one
// result transfer {overflow, fraction, intersection, union} and clears all totals,
// the table fill and the overflow flag. Code 3 is taken and ignored. Totals saturate
// at 2^24-1; the fraction is floor(intersection*65536/union) in Q1.16, capped at
// 65536 and 0 for an empty union. The block works on one transfer at a time and
// drops s_axis_tready meanwhile. Load and compare scan the table through its single
// registered read port, one entry per cycle, up to the current table fill. Finish
// runs a restoring divider on the shared 26-bit adder, one quotient bit per cycle,
// and skips the division when the union is zero. A finished result sits in the
// master output register, so loads and compares proceed while it waits; a finish
// waits there only if the previous result has not been taken.
module weighted_set_similarity_unit #(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned KEY_BITS    = 32,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // slave stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: entry_key [KEY_BITS-1:0], entry_count above it, zero pad to bytes
    input  logic [((KEY_BITS+COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: operation [1:0]
    input  logic [1:0]                             s_axis_tuser,
    // master stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: union_size [24:0], intersection_size [48:25],
    //        similarity_fraction [65:49], table_overflow [66], zero pad
    output logic [wss_pkg::M_DATA_W-1:0]           m_axis_tdata
);
    import wss_pkg::*;

    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);
    // adder must hold a 26-bit division trial and a full count plus carry
    localparam int unsigned ALU_W  = (COUNT_BITS + 1 > UNION_W + 1) ? COUNT_BITS + 1
                                                                     : UNION_W + 1;

    // ---------------- registers ----------------
    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;

    logic [USED_W-1:0]       used_reg, used_next;
    logic [TOTAL_W-1:0]      total_a_reg, total_a_next;
    logic [TOTAL_W-1:0]      total_b_reg, total_b_next;
    logic [TOTAL_W-1:0]      shared_reg, shared_next;
    logic                    ovf_reg, ovf_next;

    // scan pipeline
    logic [USED_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_pos_reg, hit_pos_next;
    logic [COUNT_BITS-1:0]   hit_cnt_reg, hit_cnt_next;

    // divider
    logic [UNION_W-1:0]      uni_reg, uni_next;
    logic [UNION_W-1:0]      rem_reg, rem_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [FRAC_W-1:0]       quo_reg, quo_next;
    logic                    qsat_reg, qsat_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [UNION_W-1:0]      out_uni_reg, out_uni_next;
    logic [TOTAL_W-1:0]      out_int_reg, out_int_next;
    logic [FRAC_W-1:0]       out_frac_reg, out_frac_next;
    logic                    out_ovf_reg, out_ovf_next;

    // table memory
    logic [KEY_BITS-1:0]     key_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]   cnt_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]     key_rd_reg;
    logic [COUNT_BITS-1:0]   cnt_rd_reg;
    logic                    rd_en;
    logic                    key_we;
    logic                    cnt_we;
    logic [IDX_W-1:0]        wr_addr;

    // shared adder/subtractor
    logic [ALU_W-1:0]        alu_a;
    logic [ALU_W-1:0]        alu_b;
    logic                    alu_sub;
    logic [ALU_W:0]          alu_res;
    logic                    alu_borrow;
    logic [TOTAL_W-1:0]      alu_sat;

    logic                    in_xfer;
    logic                    match;
    logic                    out_free;
    logic [COUNT_BITS-1:0]   min_cnt;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign match         = pend_reg && (key_rd_reg == key_reg);
    assign min_cnt       = (hit_cnt_reg < cnt_reg) ? hit_cnt_reg : cnt_reg;

    assign m_axis_tdata = {{(M_DATA_W - UNION_W - TOTAL_W - FRAC_W - 1){1'b0}},
                           out_ovf_reg, out_frac_reg, out_int_reg, out_uni_reg};

    // ---------------- shared arithmetic unit ----------------
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_FIX: begin
                alu_a   = ALU_W'(total_a_reg);
                alu_b   = ALU_W'(hit_cnt_reg);
                alu_sub = 1'b1;
            end
            ST_ACC_A: begin
                alu_a = ALU_W'(total_a_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            ST_ACC_B: begin
                alu_a = ALU_W'(total_b_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            ST_ACC_S: begin
                alu_a = ALU_W'(shared_reg);
                alu_b = ALU_W'(min_cnt);
            end
            ST_UNI_ADD: begin
                alu_a = ALU_W'(total_a_reg);
                alu_b = ALU_W'(total_b_reg);
            end
            ST_UNI_SUB: begin
                alu_a   = ALU_W'(uni_reg);
                alu_b   = ALU_W'(shared_reg);
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                // trial: shifted remainder minus divisor
                alu_a   = ALU_W'({rem_reg, dvd_reg[DVD_W-1]});
                alu_b   = ALU_W'(uni_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_res[ALU_W];
    assign alu_sat    = (alu_res > (ALU_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : alu_res[TOTAL_W-1:0];

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    priority if (s_axis_tuser == OP_LOAD || s_axis_tuser == OP_COMPARE) begin
                        state_next = ST_SCAN;
                    end else if (s_axis_tuser == OP_FINISH) begin
                        state_next = ST_UNI_ADD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (match || (!pend_reg && (rd_idx_reg >= used_reg))) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                priority if (op_reg == OP_COMPARE) begin
                    state_next = ST_ACC_B;
                end else if (hit_reg) begin
                    state_next = ST_FIX;
                end else if (used_reg < USED_W'(TABLE_DEPTH)) begin
                    state_next = ST_ACC_A;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIX:     state_next = ST_ACC_A;
            ST_ACC_A:   state_next = ST_IDLE;
            ST_ACC_B:   state_next = hit_reg ? ST_ACC_S : ST_IDLE;
            ST_ACC_S:   state_next = ST_IDLE;
            ST_UNI_ADD: state_next = ST_UNI_SUB;
            ST_UNI_SUB: begin
                state_next = (alu_res[UNION_W-1:0] == '0) ? ST_FINAL : ST_DIV;
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(DVD_W - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        op_next       = op_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        used_next     = used_reg;
        total_a_next  = total_a_reg;
        total_b_next  = total_b_reg;
        shared_next   = shared_reg;
        ovf_next      = ovf_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        hit_pos_next  = hit_pos_reg;
        hit_cnt_next  = hit_cnt_reg;
        uni_next      = uni_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        qsat_next     = qsat_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        out_uni_next  = out_uni_reg;
        out_int_next  = out_int_reg;
        out_frac_next = out_frac_reg;
        out_ovf_next  = out_ovf_reg;
        rd_en         = 1'b0;
        key_we        = 1'b0;
        cnt_we        = 1'b0;
        wr_addr       = used_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    op_next     = s_axis_tuser;
                    key_next    = s_axis_tdata[KEY_BITS-1:0];
                    cnt_next    = s_axis_tdata[KEY_BITS +: COUNT_BITS];
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                end
            end
            ST_SCAN: begin
                // one read issued and one key checked per cycle
                if (match) begin
                    hit_next     = 1'b1;
                    hit_pos_next = chk_idx_reg;
                    hit_cnt_next = cnt_rd_reg;
                    pend_next    = 1'b0;
                end else if (rd_idx_reg < used_reg) begin
                    rd_en        = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_RESOLVE: begin
                if (op_reg == OP_LOAD && !hit_reg) begin
                    if (used_reg < USED_W'(TABLE_DEPTH)) begin
                        key_we    = 1'b1;
                        cnt_we    = 1'b1;
                        used_next = used_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FIX: begin
                // write the new count over the hit entry and take the old count back out, clamped at zero
                cnt_we       = 1'b1;
                wr_addr      = hit_pos_reg;
                total_a_next = alu_borrow ? '0 : alu_res[TOTAL_W-1:0];
            end
            ST_ACC_A:   total_a_next = alu_sat;
            ST_ACC_B:   total_b_next = alu_sat;
            ST_ACC_S:   shared_next  = alu_sat;
            ST_UNI_ADD: uni_next     = alu_res[UNION_W-1:0];
            ST_UNI_SUB: begin
                uni_next  = alu_res[UNION_W-1:0];
                rem_next  = '0;
                dvd_next  = {shared_reg, {FRAC_FB{1'b0}}};
                quo_next  = '0;
                qsat_next = 1'b0;
                step_next = '0;
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_next  = alu_borrow ? alu_a[UNION_W-1:0] : alu_res[UNION_W-1:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                qsat_next = qsat_reg || quo_reg[FRAC_W-1];
                quo_next  = {quo_reg[FRAC_W-2:0], !alu_borrow};
                step_next = step_reg + 1'b1;
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_uni_next  = uni_reg;
                    out_int_next  = shared_reg;
                    out_frac_next = (qsat_reg || quo_reg > FRAC_ONE) ? FRAC_ONE : quo_reg;
                    out_ovf_next  = ovf_reg;
                    used_next     = '0;
                    total_a_next  = '0;
                    total_b_next  = '0;
                    shared_next   = '0;
                    ovf_next      = 1'b0;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // ---------------- table memory ----------------
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_reg;
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
            cnt_rd_reg <= cnt_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            total_a_reg <= '0;
            total_b_reg <= '0;
            shared_reg  <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_a_reg <= total_a_next;
            total_b_reg <= total_b_next;
            shared_reg  <= shared_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        hit_pos_reg  <= hit_pos_next;
        hit_cnt_reg  <= hit_cnt_next;
        uni_reg      <= uni_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        qsat_reg     <= qsat_next;
        step_reg     <= step_next;
        out_uni_reg  <= out_uni_next;
        out_int_reg  <= out_int_next;
        out_frac_reg <= out_frac_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // ---------------- assertions ----------------
    `include "weighted_set_similarity_unit_assert.svh"

    `WSSU_ASSERT_ALWAYS(a_used_bound, aclk, aresetn, used_reg <= USED_W'(TABLE_DEPTH),
                        "table fill beyond depth")
    `WSSU_ASSERT_ALWAYS(a_shared_le_b, aclk, aresetn, shared_reg <= total_b_reg,
                        "intersection exceeds B total")
    `WSSU_ASSERT_IMPLY(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, uni_reg != '0,
                       "division by zero union")
    `WSSU_ASSERT_IMPLY(a_frac_cap, aclk, aresetn, m_valid_reg, out_frac_reg <= FRAC_ONE,
                       "fraction above one")

endmodule
